// ===== sv/tgard_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgard_pkg
// Shared types, codes and color conversion for the TGA RLE pixel decoder.
// ----------------------------------------------------------------------------
package tgard_pkg;

	// input operation codes
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PAL   = 2'd1,
		OP_DATA  = 2'd2,
		OP_ADV   = 2'd3
	} op_t;

	// result status codes
	localparam logic [2:0] ST_TAKEN   = 3'd0;
	localparam logic [2:0] ST_PIXEL   = 3'd1;
	localparam logic [2:0] ST_BUSY    = 3'd2;
	localparam logic [2:0] ST_INDEX   = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_IMAGE_TYPE  = 3'd0;
	localparam logic [2:0] REG_PIXEL_DEPTH = 3'd1;
	localparam logic [2:0] REG_PAL_DEPTH   = 3'd2;
	localparam logic [2:0] REG_WIDTH       = 3'd3;
	localparam logic [2:0] REG_HEIGHT      = 3'd4;
	localparam logic [2:0] REG_ORIGIN      = 3'd5;
	localparam logic [2:0] REG_PAL_FIRST   = 3'd6;
	localparam logic [2:0] REG_PAL_LENGTH  = 3'd7;

	// color source for a pixel in flight
	typedef enum logic [1:0] {
		SEL_DIRECT = 2'd0,
		SEL_PAL    = 2'd1,
		SEL_RUN    = 2'd2
	} sel_t;

	typedef struct packed {
		logic [3:0]  image_type;
		logic [5:0]  pixel_depth;
		logic [5:0]  pal_depth;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [1:0]  origin_bits;
		logic [15:0] pal_first;
		logic [15:0] pal_length;
	} cfg_t;

	// palette memory access from the front end
	typedef struct packed {
		logic        we;
		logic [15:0] waddr;
		logic [31:0] wdata;
		logic        re;
		logic [15:0] raddr;
	} pal_req_t;

	// stage one result
	typedef struct packed {
		logic [2:0]  status;
		sel_t        sel;
		logic [31:0] rgba;
		logic [11:0] x;
		logic [11:0] y;
		logic        run_pending;
		logic        last;
		logic        cap_run;
	} s1_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		widen5 = {v, v[4:2]};
	endfunction

	// stored color to rgba, red in the low byte
	function automatic logic [31:0] convert_color(input logic [31:0] v,
			input logic [5:0] bits);
		if (bits == 6'd15 || bits == 6'd16)
			convert_color = {8'hFF, widen5(v[4:0]), widen5(v[9:5]), widen5(v[14:10])};
		else if (bits == 6'd24)
			convert_color = {8'hFF, v[7:0], v[15:8], v[23:16]};
		else
			convert_color = {v[31:24], v[7:0], v[15:8], v[23:16]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/tga_rle_pixel_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// TGA pixel stream decoder: raw and RLE packets to RGBA pixels with position.
// ----------------------------------------------------------------------------
// Every transfer on the slave side gives exactly one result transfer. The
// unit takes one item per clock while the output is not stalled; a result
// passes through the stage one register, then the output register, and the
// palette memory read is registered alongside stage one; palette entries are
// converted to RGBA when written. The palette needs no clearing after reset;
// entries must be written before indexed pixels refer to them. Configuration
// must be written while the unit is idle; the unit itself does not check.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit #(
	parameter int PALETTE_DEPTH = 256,
	parameter int MAX_DIM       = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // data_byte, palette_slot, palette_raw
	input  wire logic [1:0]  s_tuser,  // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// red, green, blue, alpha, screen_x, screen_y, run_pending, zero fill
	output logic [63:0]      m_tdata,
	output logic [2:0]       m_tuser,  // status
	output logic             m_tlast   // last_pixel
);
	import tgard_pkg::*;

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	cfg_t        cfg_q;
	s1_t         s1;
	pal_req_t    pal;
	logic        s1_valid, move;
	logic [31:0] pal_rdata, color, run_color_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_type   <= 4'd2;
			cfg_q.pixel_depth  <= 6'd24;
			cfg_q.pal_depth    <= 6'd24;
			cfg_q.image_width  <= 13'd1;
			cfg_q.image_height <= 13'd1;
			cfg_q.origin_bits  <= 2'd0;
			cfg_q.pal_first    <= 16'd0;
			cfg_q.pal_length   <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_TYPE:  cfg_q.image_type   <= cfg_data[3:0];
				REG_PIXEL_DEPTH: cfg_q.pixel_depth  <= cfg_data[5:0];
				REG_PAL_DEPTH:   cfg_q.pal_depth    <= cfg_data[5:0];
				REG_WIDTH:       cfg_q.image_width  <= cfg_data[12:0];
				REG_HEIGHT:      cfg_q.image_height <= cfg_data[12:0];
				REG_ORIGIN:      cfg_q.origin_bits  <= cfg_data[1:0];
				REG_PAL_FIRST:   cfg_q.pal_first    <= cfg_data;
				REG_PAL_LENGTH:  cfg_q.pal_length   <= cfg_data;
				default: ;
			endcase
		end
	end

	tgard_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.adv(move),
		.s1_valid(s1_valid),
		.s1(s1),
		.pal(pal)
	);

	tgard_pal_ram #(
		.DEPTH(PALETTE_DEPTH),
		.AW(AW)
	) u_pal (
		.clk(clk),
		.we(pal.we),
		.waddr(pal.waddr[AW-1:0]),
		.wdata(pal.wdata),
		.re(pal.re),
		.raddr(pal.raddr[AW-1:0]),
		.rdata(pal_rdata)
	);

	// color source select
	always_comb begin
		case (s1.sel)
			SEL_PAL: color = pal_rdata;
			SEL_RUN: color = run_color_q;
			default: color = s1.rgba;
		endcase
	end

	assign move = s1_valid && (!m_tvalid || m_tready);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (move)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			m_tdata <= {7'b0, s1.run_pending, s1.y, s1.x,
				color[31:24], color[23:16], color[15:8], color[7:0]};
			m_tuser <= s1.status;
			m_tlast <= s1.last;
		end
	end

	// run color kept for later advance transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			run_color_q <= '0;
		else if (move && s1.cap_run)
			run_color_q <= color;
	end

	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == ST_PIXEL)
		else $error("last pixel flag on a non-pixel result");
	a_no_color_without_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_PIXEL |-> m_tdata[55:0] == 56'd0)
		else $error("color or position on a non-pixel result");
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid && m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");
endmodule
`default_nettype wire

// ===== sv/tgard_pal_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgard_pal_ram
// Palette memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module tgard_pal_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [31:0]        rdata
);
	logic [31:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read port, data held until next read
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/tgard_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgard_front
// Packet parsing, pixel assembly, position tracking and stage one register.
// ----------------------------------------------------------------------------
module tgard_front #(
	parameter int PALETTE_DEPTH = 256,
	parameter int MAX_DIM       = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tgard_pkg::cfg_t     cfg,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [55:0]         s_tdata,
	input  wire logic [1:0]          s_tuser,
	input  wire logic                adv,
	output logic                     s1_valid,
	output tgard_pkg::s1_t           s1,
	output tgard_pkg::pal_req_t      pal
);
	import tgard_pkg::*;

	localparam logic [16:0] PAL_DEPTH_W = 17'(PALETTE_DEPTH);
	localparam logic [16:0] MAX_DIM_W   = 17'(MAX_DIM);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_ACTIVE = 3'b010,
		PH_RUNCOL = 3'b100
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] ba_q, ba_n, ba_t;
	logic [2:0]  bg_q, bg_n, bg_t, npb;
	logic [12:0] col_q, col_n, row_q, row_n, fw_q, fw_n, fh_q, fh_n, col_inc;
	logic [25:0] left_q, left_n;
	logic [7:0]  run_q, run_n, raw_q, raw_n, count;
	logic [12:0] x_full, y_full;
	logic [15:0] pidx_raw, pidx;
	logic [3:0]  npb_raw;
	logic        accept, emit, pal_err;
	op_t         op;
	s1_t         s1_n;
	logic [7:0]  dbyte;

	assign op       = op_t'(s_tuser);
	assign dbyte    = s_tdata[7:0];
	assign s_tready = !s1_valid || adv;
	assign accept   = s_tvalid && s_tready;

	function automatic logic [12:0] clamp_dim(input logic [12:0] d);
		if (d == 13'd0)
			clamp_dim = 13'd1;
		else if ({4'b0, d} > MAX_DIM_W)
			clamp_dim = MAX_DIM_W[12:0];
		else
			clamp_dim = d;
	endfunction

	// bytes per stored pixel, clamped to one through four
	always_comb begin
		npb_raw = 4'(({1'b0, cfg.pixel_depth} + 7'd7) >> 3);
		if (npb_raw == 4'd0)
			npb = 3'd1;
		else if (npb_raw > 4'd4)
			npb = 3'd4;
		else
			npb = npb_raw[2:0];
	end

	// next state for the accepted item
	always_comb begin
		phase_n = phase_q;
		ba_n    = ba_q;
		bg_n    = bg_q;
		col_n   = col_q;
		row_n   = row_q;
		fw_n    = fw_q;
		fh_n    = fh_q;
		left_n  = left_q;
		run_n   = run_q;
		raw_n   = raw_q;
		emit    = 1'b0;
		s1_n    = '0;
		s1_n.status = ST_TAKEN;
		s1_n.sel    = SEL_DIRECT;
		pal     = '0;
		count   = 8'({1'b0, dbyte[6:0]} + 8'd1);
		ba_t    = ba_q | ({24'b0, dbyte} << {bg_q[1:0], 3'b000});
		bg_t    = bg_q + 3'd1;
		pidx_raw = (npb == 3'd2) ? ba_t[15:0] : {8'b0, ba_t[7:0]};
		pidx    = pidx_raw - cfg.pal_first;
		pal_err = (pidx_raw < cfg.pal_first) || (pidx >= cfg.pal_length) ||
			({1'b0, pidx} >= PAL_DEPTH_W);
		x_full  = '0;
		y_full  = '0;
		col_inc = col_q + 13'd1;

		unique case (op)
			OP_START: begin
				fw_n    = clamp_dim(cfg.image_width);
				fh_n    = clamp_dim(cfg.image_height);
				left_n  = fw_n * fh_n;
				col_n   = '0;
				row_n   = '0;
				run_n   = '0;
				raw_n   = '0;
				ba_n    = '0;
				bg_n    = '0;
				phase_n = PH_ACTIVE;
			end
			OP_PAL: begin
				if ({1'b0, s_tdata[23:8]} < PAL_DEPTH_W) begin
					pal.we    = 1'b1;
					pal.waddr = s_tdata[23:8];
					pal.wdata = convert_color(s_tdata[55:24], cfg.pal_depth);
				end else begin
					s1_n.status = ST_IGNORED;
				end
			end
			OP_ADV: begin
				if (phase_q == PH_ACTIVE && run_q != 8'd0) begin
					run_n     = run_q - 8'd1;
					emit      = 1'b1;
					s1_n.sel  = SEL_RUN;
				end else begin
					s1_n.status = ST_IGNORED;
				end
			end
			OP_DATA: begin
				if (phase_q == PH_IDLE) begin
					s1_n.status = ST_IGNORED;
				end else if (phase_q == PH_ACTIVE && run_q != 8'd0) begin
					s1_n.status = ST_BUSY;
				end else if (phase_q == PH_ACTIVE && cfg.image_type >= 4'd9 &&
						raw_q == 8'd0) begin
					// packet header, count clamped to what is left
					if ({18'b0, count} > left_q)
						count = left_q[7:0];
					if (dbyte[7]) begin
						run_n   = count;
						phase_n = PH_RUNCOL;
					end else begin
						raw_n = count;
					end
				end else if (bg_t >= npb) begin
					ba_n = '0;
					bg_n = '0;
					if (cfg.image_type[2:0] == 3'd1 && pal_err) begin
						phase_n     = PH_IDLE;
						run_n       = '0;
						raw_n       = '0;
						s1_n.status = ST_INDEX;
					end else begin
						emit = 1'b1;
						if (cfg.image_type[2:0] == 3'd1) begin
							s1_n.sel = SEL_PAL;
							pal.re    = 1'b1;
							pal.raddr = pidx;
						end else if (cfg.image_type[2:0] == 3'd3) begin
							s1_n.rgba = {8'hFF, ba_t[7:0], ba_t[7:0], ba_t[7:0]};
						end else begin
							s1_n.rgba = convert_color(ba_t, cfg.pixel_depth);
						end
						if (phase_q == PH_RUNCOL) begin
							phase_n      = PH_ACTIVE;
							s1_n.cap_run = 1'b1;
							if (run_q != 8'd0)
								run_n = run_q - 8'd1;
						end else if (raw_q != 8'd0) begin
							raw_n = raw_q - 8'd1;
						end
					end
				end else begin
					ba_n = ba_t;
					bg_n = bg_t;
				end
			end
			default: ;
		endcase

		// pixel position and frame end
		if (emit) begin
			s1_n.status = ST_PIXEL;
			x_full = cfg.origin_bits[0] ? (fw_q - 13'd1 - col_q) : col_q;
			y_full = cfg.origin_bits[1] ? row_q : (fh_q - 13'd1 - row_q);
			s1_n.x    = x_full[11:0];
			s1_n.y    = y_full[11:0];
			s1_n.last = (left_q <= 26'd1);
			if (col_inc >= fw_q) begin
				col_n = '0;
				row_n = row_q + 13'd1;
			end else begin
				col_n = col_inc;
			end
			if (left_q != 26'd0)
				left_n = left_q - 26'd1;
			if (s1_n.last) begin
				phase_n = PH_IDLE;
				run_n   = '0;
				raw_n   = '0;
				ba_n    = '0;
				bg_n    = '0;
			end
		end
		s1_n.run_pending = (run_n != 8'd0);
		if (!accept)
			pal = '0;
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ba_q    <= '0;
			bg_q    <= '0;
			col_q   <= '0;
			row_q   <= '0;
			fw_q    <= 13'd1;
			fh_q    <= 13'd1;
			left_q  <= 26'd1;
			run_q   <= '0;
			raw_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			ba_q    <= ba_n;
			bg_q    <= bg_n;
			col_q   <= col_n;
			row_q   <= row_n;
			fw_q    <= fw_n;
			fh_q    <= fh_n;
			left_q  <= left_n;
			run_q   <= run_n;
			raw_q   <= raw_n;
		end
	end

	// stage one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (accept)
			s1_valid <= 1'b1;
		else if (adv)
			s1_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			s1 <= s1_n;
	end

	a_idle_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> run_q == 8'd0 && raw_q == 8'd0)
		else $error("run or raw count left while idle");
	a_runcol_has_run: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RUNCOL |-> run_q != 8'd0 && raw_q == 8'd0)
		else $error("run color phase without a run");
endmodule
`default_nettype wire
